// ===== design/cfcg_pkg.sv =====
package cfcg_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SAMPLE_WIDTH  = 24;

    // residual, sine-term and product widths
    localparam int EW  = SAMPLE_WIDTH + 3;
    localparam int SFW = SAMPLE_WIDTH + 2;
    localparam int MW  = SAMPLE_WIDTH + 18;

    localparam int IN_W  = ((32 + SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int OUT_W = 320;

    localparam logic [7:0] REG_AMPLITUDE = 8'd0;
    localparam logic [7:0] REG_FREQUENCY = 8'd1;
    localparam logic [7:0] REG_PHASE     = 8'd2;
    localparam logic [7:0] REG_OFFSET    = 8'd3;

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic [31:0] PI_LO = 32'h2168_C234;
    localparam logic [31:0] PI_HI = 32'hC90F_DAA2;
    localparam logic [62:0] COST_MAX = {63{1'b1}};

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [32:0] z;
    } cfcg_rot_t;

    typedef struct packed {
        logic [63:0]                    tq;
        logic signed [SAMPLE_WIDTH-1:0] value;
        logic                           last;
        logic [1:0]                     quad;
    } cfcg_pay_t;

    function automatic logic [31:0] atan_step(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10679838;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // round half up from q3.30 to q1.16, clamp to one
    function automatic logic signed [17:0] to_q16(input logic signed [33:0] v);
        logic signed [34:0] a;
        logic signed [20:0] r;
        logic signed [17:0] q;
        a = 35'(v) + 35'sd8192;
        r = 21'(a >>> 14);
        if (r > 21'sd65536)
            q = 18'sd65536;
        else if (r < -21'sd65536)
            q = -18'sd65536;
        else
            q = 18'(r);
        return q;
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        logic signed [63:0] r;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63])
            r = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        else
            r = s;
        return r;
    endfunction

endpackage

// ===== design/cosine_fit_cost_gradient_unit.sv =====
// cosine model least-squares cost and gradient unit
//
// s_* carries one request per sample: tdata holds sample_time (32 bits) and
// sample_value (signed, sample width), tlast marks the final sample of a set.
// the unit evaluates amplitude*cos(theta)+offset with an unrolled cordic row,
// forms the residual and sums the cost and four gradient terms, saturating.
// on a tlast sample one result request leaves on m_*: cost and the four
// gradients packed in tdata; the sums are then cleared for the next set.
//
// cfg_* writes the amplitude, frequency, phase and offset registers by index;
// it is always ready and should only be used while no samples are in flight.
//
// throughput: one sample per cycle while no result waits on m_tready. an
// accepted tlast sample passes through the product stage, one register per
// cordic cell, one cos/sin rounding stage and six gradient, accumulate and
// output stages before m_tvalid rises.
// while a result waits on m_tready low the whole pipeline holds and
// s_tready drops; nothing is lost.
// reset clears the registers, the accumulators and every valid flag.
module cosine_fit_cost_gradient_unit
    import cfcg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // sample_time, sample_value
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // cost, grad_amplitude, grad_frequency,
                                         // grad_phase, grad_offset, zero pad
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_index,
    input  logic [31:0]       cfg_data
);

    logic signed [SAMPLE_WIDTH-1:0] amp_reg, off_reg;
    logic [31:0]                    freq_reg, phase_reg;
    logic                           en;

    // front: frequency*time and time*pi partial products
    logic                           v0_reg;
    logic [31:0]                    ft_reg;
    logic [63:0]                    tpl_reg, tph_reg;
    logic signed [SAMPLE_WIDTH-1:0] x0_reg;
    logic                           l0_reg;

    // angle fold into quadrant and residual
    logic [31:0]                    theta;
    logic [1:0]                     quad;
    logic [31:0]                    resid;

    cfcg_rot_t rot_in  [CORDIC_STAGES+1];
    cfcg_pay_t pay_in  [CORDIC_STAGES+1];
    logic      vld_in  [CORDIC_STAGES+1];

    // cos/sin after the row
    logic signed [17:0]             cc, ss;
    logic signed [17:0]             cos_reg, sin_reg, cos_next, sin_next;
    cfcg_pay_t                      pay_post_reg;
    logic                           v_post_reg;

    assign cfg_ready = 1'b1;
    assign s_tready  = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg   <= '0;
            freq_reg  <= '0;
            phase_reg <= '0;
            off_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_AMPLITUDE: amp_reg   <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_FREQUENCY: freq_reg  <= cfg_data;
                REG_PHASE:     phase_reg <= cfg_data;
                REG_OFFSET:    off_reg   <= cfg_data[SAMPLE_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg     <= 1'b0;
            v_post_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg     <= s_tvalid;
            v_post_reg <= vld_in[CORDIC_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ft_reg       <= 32'(freq_reg * s_tdata[31:0]);
            tpl_reg      <= 64'(s_tdata[31:0]) * 64'(PI_LO);
            tph_reg      <= 64'(s_tdata[31:0]) * 64'(PI_HI);
            x0_reg       <= s_tdata[32 +: SAMPLE_WIDTH];
            l0_reg       <= s_tlast;
            cos_reg      <= cos_next;
            sin_reg      <= sin_next;
            pay_post_reg <= pay_in[CORDIC_STAGES];
        end
    end

    // nearest quarter turn, residual within one eighth
    always_comb
    begin
        theta = phase_reg + ft_reg;
        quad  = 2'((theta + 32'h2000_0000) >> 30);
        resid = theta - {quad, 30'd0};
    end

    assign rot_in[0].x     = GAIN_Q30;
    assign rot_in[0].y     = '0;
    assign rot_in[0].z     = 33'($signed(resid));
    assign pay_in[0].tq    = tph_reg + {32'd0, tpl_reg[63:32]};
    assign pay_in[0].value = x0_reg;
    assign pay_in[0].last  = l0_reg;
    assign pay_in[0].quad  = quad;
    assign vld_in[0]       = v0_reg;

    genvar g;
    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_cell
            cfcg_cordic_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .en         (en),
                .shift      (5'(g)),
                .angle_step (atan_step(5'(g))),
                .rot_in     (rot_in[g]),
                .pay_in     (pay_in[g]),
                .valid_in   (vld_in[g]),
                .rot_out    (rot_in[g+1]),
                .pay_out    (pay_in[g+1]),
                .valid_out  (vld_in[g+1])
            );
        end
    endgenerate

    // restore the quarter turn
    always_comb
    begin
        cc = to_q16(rot_in[CORDIC_STAGES].x);
        ss = to_q16(rot_in[CORDIC_STAGES].y);
        case (pay_in[CORDIC_STAGES].quad)
            2'd0:
            begin
                cos_next = cc;
                sin_next = ss;
            end
            2'd1:
            begin
                cos_next = -ss;
                sin_next = cc;
            end
            2'd2:
            begin
                cos_next = -cc;
                sin_next = -ss;
            end
            default:
            begin
                cos_next = ss;
                sin_next = -cc;
            end
        endcase
    end

    cfcg_grad_pipe u_grad
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .amplitude (amp_reg),
        .offset    (off_reg),
        .cos_in    (cos_reg),
        .sin_in    (sin_reg),
        .pay_in    (pay_post_reg),
        .valid_in  (v_post_reg),
        .en        (en),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== design/cfcg_cordic_cell.sv =====
module cfcg_cordic_cell
    import cfcg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic [4:0]  shift,
    input  logic [31:0] angle_step,
    input  cfcg_rot_t   rot_in,
    input  cfcg_pay_t   pay_in,
    input  logic        valid_in,
    output cfcg_rot_t   rot_out,
    output cfcg_pay_t   pay_out,
    output logic        valid_out
);

    cfcg_rot_t rot_reg, rot_next;
    cfcg_pay_t pay_reg;
    logic      valid_reg;

    always_comb
    begin
        if (!rot_in.z[32])
        begin
            rot_next.x = rot_in.x - (rot_in.y >>> shift);
            rot_next.y = rot_in.y + (rot_in.x >>> shift);
            rot_next.z = rot_in.z - $signed({1'b0, angle_step});
        end
        else
        begin
            rot_next.x = rot_in.x + (rot_in.y >>> shift);
            rot_next.y = rot_in.y - (rot_in.x >>> shift);
            rot_next.z = rot_in.z + $signed({1'b0, angle_step});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
            pay_reg <= pay_in;
        end
    end

    assign rot_out   = rot_reg;
    assign pay_out   = pay_reg;
    assign valid_out = valid_reg;

endmodule

// ===== design/cfcg_grad_pipe.sv =====
module cfcg_grad_pipe
    import cfcg_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [SAMPLE_WIDTH-1:0] amplitude,
    input  logic signed [SAMPLE_WIDTH-1:0] offset,
    input  logic signed [17:0]             cos_in,
    input  logic signed [17:0]             sin_in,
    input  cfcg_pay_t                      pay_in,
    input  logic                           valid_in,
    output logic                           en,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_W-1:0]               m_tdata  // cost, grad_amplitude, grad_frequency,
                                                    // grad_phase, grad_offset, zero pad
);

    // g1: amplitude products
    logic                    v1_reg;
    cfcg_pay_t               p1_reg;
    logic signed [17:0]      c1_reg;
    logic signed [MW-1:0]    mc_reg, ms_reg;

    // g2: residual and sine term
    logic                    v2_reg;
    cfcg_pay_t               p2_reg;
    logic signed [17:0]      c2_reg;
    logic signed [EW-1:0]    e_reg, e_next;
    logic signed [SFW-1:0]   sf_reg, sf_next;
    logic signed [MW:0]      mc_rnd, ms_rnd;

    // g3: per-sample terms
    logic                    v3_reg;
    logic [63:0]             tq3_reg;
    logic                    l3_reg;
    logic [2*EW-1:0]         e2_reg;
    logic signed [EW+18:0]   ga_reg;
    logic signed [EW+SFW:0]  gp_reg;
    logic signed [EW:0]      go_reg;
    logic signed [EW+SFW-1:0] pr_reg;
    logic signed [EW:0]      e_x2;
    logic signed [2*EW-1:0]  e2_full;

    // g4: partial products of the frequency term
    logic                    v4_reg;
    logic                    l4_reg;
    logic [2*EW-1:0]         e2_4_reg;
    logic signed [EW+18:0]   ga4_reg;
    logic signed [EW+SFW:0]  gp4_reg;
    logic signed [EW:0]      go4_reg;
    logic                    neg4_reg;
    logic [63:0]             pll_reg, plh_reg, phl_reg, phh_reg;
    logic [63:0]             pmag;
    logic signed [63:0]      pr64;

    // g5: frequency term
    logic                    v5_reg;
    logic                    l5_reg;
    logic [2*EW-1:0]         e2_5_reg;
    logic signed [EW+18:0]   ga5_reg;
    logic signed [EW+SFW:0]  gp5_reg;
    logic signed [EW:0]      go5_reg;
    logic signed [63:0]      gf5_reg, gf_next;
    logic [127:0]            full;
    logic [63:0]             fm;

    // accumulators and result
    logic [62:0]             cost_reg, cost_next;
    logic signed [63:0]      ga_sum_reg, ga_sum_next;
    logic signed [63:0]      gf_sum_reg, gf_sum_next;
    logic signed [63:0]      gp_sum_reg, gp_sum_next;
    logic signed [63:0]      go_sum_reg, go_sum_next;
    logic [63:0]             cost_add;
    logic                    out_valid_reg;
    logic [OUT_W-1:0]        out_data_reg;

    assign en = !out_valid_reg || m_tready;

    always_comb
    begin
        mc_rnd  = (MW+1)'(mc_reg) + (MW+1)'(32768);
        ms_rnd  = (MW+1)'(ms_reg) + (MW+1)'(32768);
        e_next  = EW'(mc_rnd >>> 16) + EW'(offset) - EW'(p1_reg.value);
        sf_next = SFW'(ms_rnd >>> 16);
        e_x2    = (EW+1)'(e_reg) <<< 1;
        e2_full = (2*EW)'(e_reg) * (2*EW)'(e_reg);
    end

    always_comb
    begin
        pr64 = 64'(pr_reg);
        pmag = pr64[63] ? (64'd0 - pr64) : pr64;
    end

    always_comb
    begin
        full = 128'(pll_reg) + (128'(plh_reg) << 32) + (128'(phl_reg) << 32)
             + (128'(phh_reg) << 64);
        fm = full[123:60];
        gf_next = neg4_reg ? -$signed(fm) : $signed(fm);
    end

    always_comb
    begin
        cost_add    = {1'b0, cost_reg} + 64'(e2_5_reg);
        cost_next   = cost_add[63] ? COST_MAX : cost_add[62:0];
        ga_sum_next = sat_add(ga_sum_reg, 64'(ga5_reg));
        gf_sum_next = sat_add(gf_sum_reg, gf5_reg);
        gp_sum_next = sat_add(gp_sum_reg, 64'(gp5_reg));
        go_sum_next = sat_add(go_sum_reg, 64'(go5_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            cost_reg      <= '0;
            ga_sum_reg    <= '0;
            gf_sum_reg    <= '0;
            gp_sum_reg    <= '0;
            go_sum_reg    <= '0;
        end
        else
        begin
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            if (en)
            begin
                v1_reg <= valid_in;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
                v4_reg <= v3_reg;
                v5_reg <= v4_reg;
                if (v5_reg)
                begin
                    if (l5_reg)
                    begin
                        out_valid_reg <= 1'b1;
                        cost_reg      <= '0;
                        ga_sum_reg    <= '0;
                        gf_sum_reg    <= '0;
                        gp_sum_reg    <= '0;
                        go_sum_reg    <= '0;
                    end
                    else
                    begin
                        cost_reg   <= cost_next;
                        ga_sum_reg <= ga_sum_next;
                        gf_sum_reg <= gf_sum_next;
                        gp_sum_reg <= gp_sum_next;
                        go_sum_reg <= go_sum_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg   <= pay_in;
            c1_reg   <= cos_in;
            mc_reg   <= MW'(amplitude) * MW'(cos_in);
            ms_reg   <= MW'(amplitude) * MW'(sin_in);

            p2_reg   <= p1_reg;
            c2_reg   <= c1_reg;
            e_reg    <= e_next;
            sf_reg   <= sf_next;

            tq3_reg  <= p2_reg.tq;
            l3_reg   <= p2_reg.last;
            e2_reg   <= e2_full;
            ga_reg   <= (EW+19)'(e_x2) * (EW+19)'(c2_reg);
            gp_reg   <= -((EW+SFW+1)'(e_x2) * (EW+SFW+1)'(sf_reg));
            go_reg   <= e_x2;
            pr_reg   <= (EW+SFW)'(e_reg) * (EW+SFW)'(sf_reg);

            l4_reg   <= l3_reg;
            e2_4_reg <= e2_reg;
            ga4_reg  <= ga_reg;
            gp4_reg  <= gp_reg;
            go4_reg  <= go_reg;
            neg4_reg <= !pr_reg[EW+SFW-1];
            pll_reg  <= 64'(pmag[31:0])  * 64'(tq3_reg[31:0]);
            plh_reg  <= 64'(pmag[31:0])  * 64'(tq3_reg[63:32]);
            phl_reg  <= 64'(pmag[63:32]) * 64'(tq3_reg[31:0]);
            phh_reg  <= 64'(pmag[63:32]) * 64'(tq3_reg[63:32]);

            l5_reg   <= l4_reg;
            e2_5_reg <= e2_4_reg;
            ga5_reg  <= ga4_reg;
            gp5_reg  <= gp4_reg;
            go5_reg  <= go4_reg;
            gf5_reg  <= gf_next;

            if (v5_reg && l5_reg)
                out_data_reg <= {1'b0, go_sum_next, gp_sum_next, gf_sum_next,
                                 ga_sum_next, cost_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

// testbench for cosine_fit_cost_gradient_unit
//
// samples are queued phase by phase by the stimulus block and streamed in by
// a clocked driver with random gaps. every accepted sample runs through a
// local cordic/cost/gradient predictor, and a sample carrying tlast pushes
// the five expected sums. a clocked monitor with random back-pressure checks
// each result request against the oldest expected set, field by field.
// between phases the sender drains every result, the pipeline is allowed to
// empty, then the model registers are rewritten (extremes included).
module testbench;
    import cfcg_pkg::*;

    localparam longint     CORDIC_GAIN = 64'sd652032874;
    localparam logic [63:0] PI_Q62     = 64'hC90F_DAA2_2168_C234;
    localparam logic [7:0] REG_UNUSED  = 8'd9;
    localparam int         DRAIN_WAIT  = CORDIC_STAGES + 20;
    localparam longint     I64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint     I64_MIN     = 64'sh8000_0000_0000_0000;

    // arctangent of 2^-i in q0.32 turns
    localparam longint ATAN_TURNS [0:31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct {
        logic [31:0]             t;
        logic [SAMPLE_WIDTH-1:0] v;
        logic                    last;
    } sample_t;

    typedef struct {
        logic [62:0] cost;
        longint      g_amp;
        longint      g_freq;
        longint      g_phase;
        longint      g_off;
    } sums_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [7:0]          cfg_index;
    logic [31:0]         cfg_data;

    // stimulus and scoreboard state
    sample_t pending_samples[$];
    sums_t   expected_sums[$];
    int      samples_queued;
    int      samples_taken;
    int      results_seen;
    int      error_count;
    int      send_gap;
    int      recv_stall;
    bit      quiet_phase;

    // predictor copy of the model registers and the running sums
    logic [SAMPLE_WIDTH-1:0] mdl_amp;
    logic [31:0]             mdl_freq;
    logic [31:0]             mdl_phase;
    logic [SAMPLE_WIDTH-1:0] mdl_off;
    logic [62:0]             acc_cost;
    longint                  acc_amp;
    longint                  acc_freq;
    longint                  acc_phase;
    longint                  acc_off;

    cosine_fit_cost_gradient_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // clamp a wide signed value into 64 bits
    function automatic longint clamp64(input logic signed [129:0] v);
        if (v > 130'sh7FFF_FFFF_FFFF_FFFF)
            return I64_MAX;
        if (v < -130'sh8000_0000_0000_0000)
            return I64_MIN;
        return longint'(v[63:0]);
    endfunction

    function automatic longint mul_clamp(input longint a, input longint b);
        logic signed [129:0] p;
        p = 130'(a) * 130'(b);
        return clamp64(p);
    endfunction

    function automatic longint add_clamp(input longint a, input longint b);
        logic signed [129:0] s;
        s = 130'(a) + 130'(b);
        return clamp64(s);
    endfunction

    function automatic longint q16_round(input longint v);
        longint r;
        r = (v + 8192) >>> 14;
        if (r > 65536)
            r = 65536;
        if (r < -65536)
            r = -65536;
        return r;
    endfunction

    // quarter fold, cordic rotation from the gain, quarter restore
    function automatic void cos_sin(input logic [31:0] ang, output longint c,
                                    output longint s);
        logic [31:0] quad;
        logic [31:0] res;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        longint      ny;
        longint      cc;
        longint      ss;
        quad = (ang + 32'h2000_0000) >> 30;
        res  = ang - (quad << 30);
        z    = longint'(signed'(res));
        x    = CORDIC_GAIN;
        y    = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - ATAN_TURNS[i];
            end
            else
            begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + ATAN_TURNS[i];
            end
            x = nx;
            y = ny;
        end
        cc = q16_round(x);
        ss = q16_round(y);
        case (quad[1:0])
            2'd0:    begin c = cc;  s = ss;  end
            2'd1:    begin c = -ss; s = cc;  end
            2'd2:    begin c = -cc; s = -ss; end
            default: begin c = ss;  s = -cc; end
        endcase
    endfunction

    // fold one sample into the running sums, push a result on tlast
    function automatic void accumulate_sample(input sample_t it);
        logic [31:0]  theta;
        logic [127:0] wide;
        logic [63:0]  tq;
        logic [63:0]  pm;
        logic [63:0]  fm;
        longint       am;
        longint       dc;
        longint       c;
        longint       s;
        longint       e;
        longint       sf;
        longint       e2;
        longint       p;
        longint       fterm;
        sums_t        r;
        am    = longint'(signed'(mdl_amp));
        dc    = longint'(signed'(mdl_off));
        theta = mdl_phase + mdl_freq * it.t;
        cos_sin(theta, c, s);
        e  = ((am * c + 32768) >>> 16) + dc - longint'(signed'(it.v));
        sf = (am * s + 32768) >>> 16;

        e2 = mul_clamp(e, e);
        if (64'(e2) > 64'(63'h7FFF_FFFF_FFFF_FFFF - acc_cost))
            acc_cost = 63'h7FFF_FFFF_FFFF_FFFF;
        else
            acc_cost = acc_cost + 63'(e2);
        acc_amp   = add_clamp(acc_amp, mul_clamp(2 * e, c));
        acc_phase = add_clamp(acc_phase, mul_clamp(-2 * e, sf));
        acc_off   = add_clamp(acc_off, 2 * e);

        // frequency term: |e*sf| * (t*pi/2^32) / 2^60, sign opposite to e*sf
        p    = mul_clamp(e, sf);
        wide = 128'(it.t) * 128'(PI_Q62);
        tq   = wide[95:32];
        pm   = (p < 0) ? 64'(-p) : 64'(p);
        wide = 128'(pm) * 128'(tq);
        fm   = (wide[127:124] != 4'd0) ? {64{1'b1}} : wide[123:60];
        if (p > 0)
            fterm = (fm > 64'h7FFF_FFFF_FFFF_FFFF) ? I64_MIN : -longint'(fm);
        else
            fterm = (fm > 64'h7FFF_FFFF_FFFF_FFFF) ? I64_MAX : longint'(fm);
        acc_freq = add_clamp(acc_freq, fterm);

        if (it.last)
        begin
            r.cost    = acc_cost;
            r.g_amp   = acc_amp;
            r.g_freq  = acc_freq;
            r.g_phase = acc_phase;
            r.g_off   = acc_off;
            expected_sums.push_back(r);
            acc_cost  = '0;
            acc_amp   = 0;
            acc_freq  = 0;
            acc_phase = 0;
            acc_off   = 0;
        end
    endfunction

    // mostly short gaps, a few long ones, none in quiet phases
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want,
                 results_seen);
        error_count++;
    endtask

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin
        sample_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (s_tvalid)
            begin
                it.t    = s_tdata[31:0];
                it.v    = s_tdata[32 +: SAMPLE_WIDTH];
                it.last = s_tlast;
                accumulate_sample(it);
                samples_taken++;
            end
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end
            else if (pending_samples.size() > 0)
            begin
                it = pending_samples.pop_front();
                s_tdata  <= {it.v, it.t};
                s_tlast  <= it.last;
                s_tvalid <= 1'b1;
                send_gap <= pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        sums_t want;
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_sums.size() == 0)
                begin
                    report_mismatch("unexpected result", m_tdata[63:0], '0);
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (m_tdata[62:0] !== want.cost)
                        report_mismatch("cost", 64'(m_tdata[62:0]), 64'(want.cost));
                    if (m_tdata[126:63] !== want.g_amp)
                        report_mismatch("grad_amplitude", m_tdata[126:63], want.g_amp);
                    if (m_tdata[190:127] !== want.g_freq)
                        report_mismatch("grad_frequency", m_tdata[190:127], want.g_freq);
                    if (m_tdata[254:191] !== want.g_phase)
                        report_mismatch("grad_phase", m_tdata[254:191], want.g_phase);
                    if (m_tdata[318:255] !== want.g_off)
                        report_mismatch("grad_offset", m_tdata[318:255], want.g_off);
                end
                results_seen++;
            end
            if (recv_stall > 0)
            begin
                recv_stall <= recv_stall - 1;
                m_tready   <= 1'b0;
            end
            else
            begin
                m_tready   <= 1'b1;
                recv_stall <= pick_gap();
            end
        end
    end

    // register copy follows every accepted write
    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_AMPLITUDE: mdl_amp   <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_FREQUENCY: mdl_freq  <= cfg_data;
                REG_PHASE:     mdl_phase <= cfg_data;
                REG_OFFSET:    mdl_off   <= cfg_data[SAMPLE_WIDTH-1:0];
                default:       ;
            endcase
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] d);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic queue_sample(input logic [31:0] t, input logic [SAMPLE_WIDTH-1:0] v,
                                input logic last);
        sample_t it;
        it.t    = t;
        it.v    = v;
        it.last = last;
        pending_samples.push_back(it);
        samples_queued++;
    endtask

    // sender holds until every result is back and the pipeline has emptied
    task automatic drain();
        @(posedge clk);
        while (samples_taken != samples_queued || expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_WIDTH-1:0] any_value();
        case ($urandom_range(0, 9))
            0:       return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            1:       return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            2:       return SAMPLE_WIDTH'($urandom_range(0, 200)) - SAMPLE_WIDTH'(100);
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] any_time();
        case ($urandom_range(0, 7))
            0:       return 32'hFFFF_FFFF;
            1:       return $urandom_range(0, 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int set_len;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        m_tready       = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        quiet_phase    = 1'b0;
        samples_queued = 0;
        samples_taken  = 0;
        results_seen   = 0;
        error_count    = 0;
        mdl_amp        = '0;
        mdl_freq       = '0;
        mdl_phase      = '0;
        mdl_off        = '0;
        acc_cost       = '0;
        acc_amp        = 0;
        acc_freq       = 0;
        acc_phase      = 0;
        acc_off        = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset registers: model is flat zero, residual is minus the sample
        queue_sample(32'd0, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}, 1'b1);
        queue_sample(32'hFFFF_FFFF, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}, 1'b0);
        queue_sample(32'd5, '0, 1'b1);
        drain();

        // full-scale amplitude, quarter-turn phase, no frequency, most negative offset
        write_reg(REG_AMPLITUDE, 32'h007F_FFFF);
        write_reg(REG_FREQUENCY, 32'd0);
        write_reg(REG_PHASE, 32'h4000_0000);
        write_reg(REG_OFFSET, 32'h0080_0000);
        // unknown index must leave the registers alone
        write_reg(REG_UNUSED, 32'hDEAD_BEEF);
        queue_sample(32'd0, {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}, 1'b0);
        queue_sample(32'hFFFF_FFFF, {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}, 1'b0);
        queue_sample(32'h8000_0000, '0, 1'b1);
        drain();

        // most negative amplitude, highest frequency, phase and offset
        write_reg(REG_AMPLITUDE, 32'h0080_0000);
        write_reg(REG_FREQUENCY, 32'hFFFF_FFFF);
        write_reg(REG_PHASE, 32'hFFFF_FFFF);
        write_reg(REG_OFFSET, 32'h007F_FFFF);
        for (int i = 0; i < 12; i++)
            queue_sample(i == 11 ? 32'hFFFF_FFFF : 32'h1000_0000 * i,
                         (i % 2) ? {1'b0, {(SAMPLE_WIDTH-1){1'b1}}}
                                 : {1'b1, {(SAMPLE_WIDTH-1){1'b0}}},
                         (i % 4) == 3);
        drain();

        // random phases: fresh registers each time, sets of random length
        for (int ph = 0; ph < 9; ph++)
        begin
            quiet_phase = (ph == 3);
            write_reg(REG_AMPLITUDE, {8'd0, any_value()});
            write_reg(REG_FREQUENCY, any_word());
            write_reg(REG_PHASE, any_word());
            write_reg(REG_OFFSET, {8'd0, any_value()});
            for (int n = 0; n < 42; )
            begin
                set_len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(1, 6);
                for (int k = 0; k < set_len; k++)
                    queue_sample(any_time(), any_value(), k == set_len - 1);
                n += set_len;
            end
            drain();
        end

        $display("covered %0d samples and %0d result sets over 12 register settings",
                 samples_queued, results_seen);
        $display("register extremes, unknown index write, random gaps and stalls");
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout");
        $display("testbench: done, errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cfcg_pkg.sv
design/cfcg_cordic_cell.sv
design/cfcg_grad_pipe.sv
design/cosine_fit_cost_gradient_unit.sv
sim/testbench.sv
